// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the distance unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/vdm_pkg.sv
// ---------------------------------------------------------------------------
// vdm_pkg
// Types, widths and constants shared by the vector distance unit.
// ---------------------------------------------------------------------------
package vdm_pkg;

    localparam int ELEM_W      = 16;
    localparam int ABS_W       = 26;
    localparam int SQ_W        = 43;
    localparam int NORM_W      = 42;
    localparam int DOT_W       = 43;
    localparam int DIST_W      = 26;
    localparam int PROD_W      = 113;
    localparam int MUL_B_W     = 43;
    localparam int MUL_STEPS   = 43;
    localparam int SQRT_STEPS  = 22;
    localparam int SRCH_W      = 15;
    localparam int ONE_Q14     = 16384;
    localparam int RHS_SHIFT   = 28;
    localparam int CNT_STEP_W  = 6;
    localparam int MAX_LEN_DEF = 1024;

    typedef enum logic [1:0] {
        MET_L1  = 2'd0,
        MET_L2  = 2'd1,
        MET_COS = 2'd2
    } metric_t;

    typedef enum logic [1:0] {
        MS_MAG = 2'd0,
        MS_X   = 2'd1,
        MS_Y   = 2'd2
    } mul_src_t;

    typedef struct packed {
        logic     in_ready;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     srch_init;
        logic     mul_load;
        mul_src_t mul_sel;
        logic     mul_step;
        logic     rhs_load;
        logic     srch_update;
        logic     out_load;
        logic     clear;
    } vdm_cmd_t;

    typedef struct packed {
        logic       s1_last;
        logic [1:0] metric;
        logic       norm_zero;
        logic       srch_done;
        logic       out_free;
    } vdm_stat_t;

endpackage

// File: hdl/vdm_datapath.sv
// ---------------------------------------------------------------------------
// vdm_datapath
// Element products, saturating sums, square root, shift-add multiplier,
// cosine search registers and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vdm_datapath #(
    parameter int MAX_LEN = vdm_pkg::MAX_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vdm_pkg::vdm_cmd_t               cmd,
    output vdm_pkg::vdm_stat_t              stat,
    input  logic                            in_valid,
    input  logic signed [vdm_pkg::ELEM_W-1:0] x_value,
    input  logic signed [vdm_pkg::ELEM_W-1:0] y_value,
    input  logic                            last_element,
    input  logic                            cfg_valid,
    input  logic [1:0]                      cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [vdm_pkg::DIST_W-1:0]      distance,
    output logic                            zero_norm,
    output logic                            overflowed
);
    import vdm_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [ABS_W-1:0]  ABS_CAP  = {ABS_W{1'b1}};
    localparam logic [SQ_W-1:0]   SQ_CAP   = {SQ_W{1'b1}};
    localparam logic [NORM_W-1:0] NORM_CAP = {NORM_W{1'b1}};
    localparam logic signed [DOT_W:0] DOT_HI = (DOT_W+1)'((64'sd1 <<< (DOT_W-1)) - 64'sd1);
    localparam logic signed [DOT_W:0] DOT_LO = (DOT_W+1)'(-(64'sd1 <<< (DOT_W-1)));

    logic                       accept;
    logic [1:0]                 metric_reg;

    // stage one: products
    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic [ELEM_W-1:0]          ad_reg;
    logic [2*ELEM_W-1:0]        ad2_reg;
    logic signed [2*ELEM_W-1:0] xy_reg;
    logic [2*ELEM_W-1:0]        xx_reg;
    logic [2*ELEM_W-1:0]        yy_reg;
    logic signed [ELEM_W:0]     diff;
    logic [ELEM_W-1:0]          ad;

    // stage two: sums
    logic [ABS_W-1:0]           abs_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic signed [DOT_W-1:0]    dot_reg;
    logic [NORM_W-1:0]          xn_reg;
    logic [NORM_W-1:0]          yn_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       ovf_reg;

    logic [ABS_W:0]             abs_sum;
    logic [SQ_W:0]              sq_sum;
    logic [NORM_W:0]            xn_sum;
    logic [NORM_W:0]            yn_sum;
    logic signed [DOT_W:0]      dot_sum;
    logic                       abs_ovf, sq_ovf, xn_ovf, yn_ovf, dot_ovf, len_ovf;

    // square root
    logic [SQ_W-1:0]            sv_reg;
    logic [SQ_W-1:0]            sr_reg;
    logic [SQ_W-1:0]            sbit_reg;
    logic [SQ_W:0]              strial;

    // multiplier and search
    logic [PROD_W-1:0]          ma_reg;
    logic [MUL_B_W-1:0]         mb_reg;
    logic [PROD_W-1:0]          macc_reg;
    logic [PROD_W-1:0]          rhs_reg;
    logic [SRCH_W-1:0]          lo_reg;
    logic [SRCH_W-1:0]          hi_reg;
    logic [SRCH_W:0]            mid_sum;
    logic [SRCH_W-1:0]          mid;
    logic [DOT_W-1:0]           mag;
    logic [SRCH_W:0]            cos_val;

    // result register
    logic                       out_valid_reg;
    logic [DIST_W-1:0]          dist_reg;
    logic                       zn_reg;
    logic                       oflag_reg;
    logic [DIST_W-1:0]          dist_next;
    logic                       zn_next;

    assign accept = in_valid & cmd.in_ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= MET_L1;
        end
        else if (cfg_valid)
        begin
            metric_reg <= cfg_data;
        end
    end

    // element difference
    always_comb
    begin
        diff = (ELEM_W+1)'(x_value) - (ELEM_W+1)'(y_value);
        ad   = diff[ELEM_W] ? ELEM_W'(-diff) : diff[ELEM_W-1:0];
    end

    // stage one: register products of the accepted pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept & last_element;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ad_reg  <= ad;
            ad2_reg <= ad * ad;
            xy_reg  <= x_value * y_value;
            xx_reg  <= (2*ELEM_W)'(x_value * x_value);
            yy_reg  <= (2*ELEM_W)'(y_value * y_value);
        end
    end

    // saturating sums
    always_comb
    begin
        abs_sum = {1'b0, abs_reg} + (ABS_W+1)'(ad_reg);
        sq_sum  = {1'b0, sq_reg} + (SQ_W+1)'(ad2_reg);
        xn_sum  = {1'b0, xn_reg} + (NORM_W+1)'(xx_reg);
        yn_sum  = {1'b0, yn_reg} + (NORM_W+1)'(yy_reg);
        dot_sum = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(xy_reg);
        abs_ovf = (abs_reg == ABS_CAP) || (abs_sum > (ABS_W+1)'(ABS_CAP));
        sq_ovf  = (sq_reg == SQ_CAP) || (sq_sum > (SQ_W+1)'(SQ_CAP));
        xn_ovf  = (xn_reg == NORM_CAP) || (xn_sum > (NORM_W+1)'(NORM_CAP));
        yn_ovf  = (yn_reg == NORM_CAP) || (yn_sum > (NORM_W+1)'(NORM_CAP));
        dot_ovf = (dot_sum > DOT_HI) || (dot_sum < DOT_LO);
        len_ovf = (cnt_reg >= CNT_W'(MAX_LEN));
    end

    // stage two: accumulate, clear after each result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_reg <= '0;
            sq_reg  <= '0;
            dot_reg <= '0;
            xn_reg  <= '0;
            yn_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            abs_reg <= '0;
            sq_reg  <= '0;
            dot_reg <= '0;
            xn_reg  <= '0;
            yn_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            abs_reg <= abs_ovf ? ABS_CAP : abs_sum[ABS_W-1:0];
            sq_reg  <= sq_ovf ? SQ_CAP : sq_sum[SQ_W-1:0];
            xn_reg  <= xn_ovf ? NORM_CAP : xn_sum[NORM_W-1:0];
            yn_reg  <= yn_ovf ? NORM_CAP : yn_sum[NORM_W-1:0];
            if (dot_sum > DOT_HI)
            begin
                dot_reg <= DOT_HI[DOT_W-1:0];
            end
            else if (dot_sum < DOT_LO)
            begin
                dot_reg <= DOT_LO[DOT_W-1:0];
            end
            else
            begin
                dot_reg <= dot_sum[DOT_W-1:0];
            end
            if (!len_ovf)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ovf_reg <= ovf_reg | abs_ovf | sq_ovf | xn_ovf | yn_ovf | dot_ovf | len_ovf;
        end
    end

    // square root, one result bit per step
    assign strial = {1'b0, sr_reg} + {1'b0, sbit_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            sv_reg   <= sq_reg;
            sr_reg   <= '0;
            sbit_reg <= SQ_W'(1) << (2 * (SQRT_STEPS - 1));
        end
        else if (cmd.sqrt_step)
        begin
            if ({1'b0, sv_reg} >= strial)
            begin
                sv_reg <= sv_reg - strial[SQ_W-1:0];
                sr_reg <= (sr_reg >> 1) + sbit_reg;
            end
            else
            begin
                sr_reg <= sr_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    // shift-add multiplier shared by the magnitude square and the norm products
    assign mag     = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + (SRCH_W+1)'(1);
    assign mid     = mid_sum[SRCH_W:1];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            macc_reg <= '0;
            case (cmd.mul_sel)
                MS_MAG:
                begin
                    ma_reg <= PROD_W'(mag);
                    mb_reg <= MUL_B_W'(mag);
                end
                MS_X:
                begin
                    ma_reg <= PROD_W'(mid * mid);
                    mb_reg <= MUL_B_W'(xn_reg);
                end
                MS_Y:
                begin
                    ma_reg <= macc_reg;
                    mb_reg <= MUL_B_W'(yn_reg);
                end
                default:
                begin
                    ma_reg <= '0;
                    mb_reg <= '0;
                end
            endcase
        end
        else if (cmd.mul_step)
        begin
            if (mb_reg[0])
            begin
                macc_reg <= macc_reg + ma_reg;
            end
            ma_reg <= ma_reg << 1;
            mb_reg <= mb_reg >> 1;
        end
        if (cmd.rhs_load)
        begin
            rhs_reg <= macc_reg << RHS_SHIFT;
        end
    end

    // binary search bounds for the cosine term
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= SRCH_W'(ONE_Q14);
        end
        else if (cmd.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= SRCH_W'(ONE_Q14);
        end
        else if (cmd.srch_update)
        begin
            if (macc_reg <= rhs_reg)
            begin
                lo_reg <= mid;
            end
            else
            begin
                hi_reg <= mid - SRCH_W'(1);
            end
        end
    end

    // result selection
    always_comb
    begin
        cos_val   = dot_reg[DOT_W-1] ? ((SRCH_W+1)'(ONE_Q14) + (SRCH_W+1)'(lo_reg))
                                     : ((SRCH_W+1)'(ONE_Q14) - (SRCH_W+1)'(lo_reg));
        dist_next = abs_reg;
        zn_next   = 1'b0;
        case (metric_reg)
            MET_L2:
            begin
                dist_next = sr_reg[DIST_W-1:0];
            end
            MET_COS:
            begin
                zn_next   = stat.norm_zero;
                dist_next = stat.norm_zero ? '0 : DIST_W'(cos_val);
            end
            default:
            begin
                dist_next = abs_reg;
            end
        endcase
    end

    // result register, freed when the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            dist_reg  <= dist_next;
            zn_reg    <= zn_next;
            oflag_reg <= ovf_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign distance   = dist_reg;
    assign zero_norm  = zn_reg;
    assign overflowed = oflag_reg;

    assign stat.s1_last   = s1_valid_reg & s1_last_reg;
    assign stat.metric    = metric_reg;
    assign stat.norm_zero = (xn_reg == '0) || (yn_reg == '0);
    assign stat.srch_done = (lo_reg >= hi_reg);
    assign stat.out_free  = ~out_valid_reg | out_ready;

    `ASSERT_IMP(a_srch_order, clk, rst_n, 1'b1, lo_reg <= hi_reg)
    `ASSERT_IMP(a_hi_bound, clk, rst_n, 1'b1, hi_reg <= SRCH_W'(ONE_Q14))
    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg)

endmodule

// File: hdl/vdm_ctrl.sv
// ---------------------------------------------------------------------------
// vdm_ctrl
// Sequencer: accumulate pairs, then run the square root (L2) or the cosine
// search (cosine, nonzero norms) and hand the result to the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vdm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  vdm_pkg::vdm_stat_t  stat,
    output vdm_pkg::vdm_cmd_t   cmd
);
    import vdm_pkg::*;

    typedef enum logic [3:0] {
        S_ACC,
        S_SEL,
        S_SQRT,
        S_MAG,
        S_RHS,
        S_MID,
        S_MX,
        S_MYL,
        S_MY,
        S_CMP,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_STEP_W-1:0]  cnt_reg, cnt_next;
    logic                   mul_last;
    logic                   sqrt_last;

    assign mul_last  = (cnt_reg == CNT_STEP_W'(MUL_STEPS - 1));
    assign sqrt_last = (cnt_reg == CNT_STEP_W'(SQRT_STEPS - 1));

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = MS_MAG;
        case (state_reg)
            S_ACC:
            begin
                cmd.in_ready = ~stat.s1_last;
                if (stat.s1_last)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                cnt_next = '0;
                if (stat.metric == MET_L2)
                begin
                    cmd.sqrt_load = 1'b1;
                    state_next    = S_SQRT;
                end
                else if (stat.metric == MET_COS && !stat.norm_zero)
                begin
                    cmd.mul_load  = 1'b1;
                    cmd.mul_sel   = MS_MAG;
                    cmd.srch_init = 1'b1;
                    state_next    = S_MAG;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + CNT_STEP_W'(1);
                if (sqrt_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_MAG:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CNT_STEP_W'(1);
                if (mul_last)
                begin
                    state_next = S_RHS;
                end
            end
            S_RHS:
            begin
                cmd.rhs_load = 1'b1;
                state_next   = S_MID;
            end
            S_MID:
            begin
                cnt_next = '0;
                if (stat.srch_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    cmd.mul_sel  = MS_X;
                    state_next   = S_MX;
                end
            end
            S_MX:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CNT_STEP_W'(1);
                if (mul_last)
                begin
                    state_next = S_MYL;
                end
            end
            S_MYL:
            begin
                cnt_next     = '0;
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = MS_Y;
                state_next   = S_MY;
            end
            S_MY:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CNT_STEP_W'(1);
                if (mul_last)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.srch_update = 1'b1;
                state_next      = S_MID;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    // hold state and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `ASSERT_IMP(a_ready_only_acc, clk, rst_n, cmd.in_ready, state_reg == S_ACC)
    `ASSERT_NXT(a_sqrt_ends, clk, rst_n, state_reg == S_SQRT && sqrt_last, state_reg == S_OUT)
    `ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_load, stat.out_free && state_reg == S_OUT)

endmodule

// File: hdl/vector_distance_metrics_unit.sv
// ---------------------------------------------------------------------------
// vector_distance_metrics_unit
// Streaming L1 / L2 / cosine distance between two Q8.8 vectors.
// ---------------------------------------------------------------------------
// One element pair is taken per cycle and runs through a two-stage
// multiply/accumulate into saturating sums. After the pair marked last, no
// pair is taken until the result is formed and the output register is free:
// L1 takes the sum as it is, L2 runs the 22 steps of the bit-serial square
// root, cosine a binary search of up to 15 steps, each step two passes of
// the shared 43-step shift-add multiplier. The result sits in an output
// register, so the next vector's pairs flow while it waits to be taken.

module vector_distance_metrics_unit #(
    parameter int MAX_LEN = vdm_pkg::MAX_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] x_value, [31:16] y_value
    input  logic        s_axis_tlast,   // last_element
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [25:0] distance, [26] zero_norm,
                                        // [27] overflowed, [31:28] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data        // metric
);
    import vdm_pkg::*;

    vdm_cmd_t           cmd;
    vdm_stat_t          stat;
    logic [DIST_W-1:0]  distance;
    logic               zero_norm;
    logic               overflowed;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {4'b0, overflowed, zero_norm, distance};

    vdm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    vdm_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_valid     (s_axis_tvalid),
        .x_value      (s_axis_tdata[15:0]),
        .y_value      (s_axis_tdata[31:16]),
        .last_element (s_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .distance     (distance),
        .zero_norm    (zero_norm),
        .overflowed   (overflowed)
    );

endmodule

// File: tb/distance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_checker
// Watches the pair, result and metric channels of the distance unit, works
// out the expected distance of every finished vector and compares it with
// each result item that the unit hands out.
// ----------------------------------------------------------------------------
module distance_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    import vdm_pkg::*;

    localparam longint unsigned ABS_LIMIT  = (64'd1 << ABS_W) - 1;
    localparam longint unsigned SQ_LIMIT   = (64'd1 << SQ_W) - 1;
    localparam longint unsigned NORM_LIMIT = (64'd1 << NORM_W) - 1;
    localparam longint          DOT_MAX    = (64'sd1 <<< 42) - 1;
    localparam longint          DOT_MIN    = -(64'sd1 <<< 42);
    localparam int              LEN_LIMIT  = MAX_LEN_DEF;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              zero_norm;
        logic              overflowed;
    } dist_result_t;

    dist_result_t    expected_results[$];
    logic [1:0]      metric_sel;
    longint unsigned abs_acc, sq_acc, xn_acc, yn_acc;
    longint          dot_acc;
    int              pair_count;
    logic            sat_flag;

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned cand;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (cand * cand <= v)
                r = cand;
        end
        return r;
    endfunction

    // Cosine distance in Q2.14 from the current sums
    function automatic longint unsigned cos_dist(longint dot, longint unsigned xn,
                                                 longint unsigned yn);
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        longint unsigned mag;
        longint unsigned lo_t;
        longint unsigned hi_t;
        longint unsigned mid;
        mag  = dot < 0 ? longint'(-dot) : longint'(dot);
        rhs  = (128'(mag) * 128'(mag)) << RHS_SHIFT;
        lo_t = 0;
        hi_t = ONE_Q14;
        while (lo_t < hi_t)
        begin
            mid = (lo_t + hi_t + 1) >> 1;
            lhs = 128'(mid * mid) * 128'(xn) * 128'(yn);
            if (lhs <= rhs)
                lo_t = mid;
            else
                hi_t = mid - 1;
        end
        return dot < 0 ? ONE_Q14 + lo_t : ONE_Q14 - lo_t;
    endfunction

    function automatic longint unsigned capped_add(longint unsigned acc, longint unsigned v,
                                                   longint unsigned cap, ref logic flag);
        if (acc >= cap || v > cap - acc)
        begin
            flag = 1'b1;
            return cap;
        end
        return acc + v;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        longint          x, y, d, p;
        longint unsigned ad;
        dist_result_t    exp_r;
        dist_result_t    got;
        if (!rst_n)
        begin
            metric_sel   = MET_L1;
            abs_acc      = 0;
            sq_acc       = 0;
            xn_acc       = 0;
            yn_acc       = 0;
            dot_acc      = 0;
            pair_count   = 0;
            sat_flag     = 1'b0;
            fail_count   = 0;
            result_count = 0;
            expected_results.delete();
        end
        else
        begin
            // Track the metric register
            if (cfg_valid && cfg_ready)
                metric_sel = cfg_data;

            // Accumulate each accepted pair
            if (s_axis_tvalid && s_axis_tready)
            begin
                x  = longint'($signed(s_axis_tdata[15:0]));
                y  = longint'($signed(s_axis_tdata[31:16]));
                d  = x - y;
                ad = d < 0 ? longint'(-d) : longint'(d);
                p  = dot_acc + x * y;
                if (pair_count >= LEN_LIMIT)
                    sat_flag = 1'b1;
                else
                    pair_count++;
                abs_acc = capped_add(abs_acc, ad, ABS_LIMIT, sat_flag);
                sq_acc  = capped_add(sq_acc, ad * ad, SQ_LIMIT, sat_flag);
                xn_acc  = capped_add(xn_acc, longint'(x * x), NORM_LIMIT, sat_flag);
                yn_acc  = capped_add(yn_acc, longint'(y * y), NORM_LIMIT, sat_flag);
                if (p > DOT_MAX)
                begin
                    p = DOT_MAX;
                    sat_flag = 1'b1;
                end
                else if (p < DOT_MIN)
                begin
                    p = DOT_MIN;
                    sat_flag = 1'b1;
                end
                dot_acc = p;

                // Form the distance on the last pair, then clear the sums
                if (s_axis_tlast)
                begin
                    exp_r.zero_norm  = 1'b0;
                    exp_r.overflowed = sat_flag;
                    if (metric_sel == MET_L2)
                        exp_r.distance = DIST_W'(int_sqrt(sq_acc));
                    else if (metric_sel == MET_COS)
                    begin
                        if (xn_acc == 0 || yn_acc == 0)
                        begin
                            exp_r.zero_norm = 1'b1;
                            exp_r.distance  = '0;
                        end
                        else
                            exp_r.distance = DIST_W'(cos_dist(dot_acc, xn_acc, yn_acc));
                    end
                    else
                        exp_r.distance = DIST_W'(abs_acc);
                    expected_results.insert(expected_results.size(), exp_r);
                    abs_acc    = 0;
                    sq_acc     = 0;
                    xn_acc     = 0;
                    yn_acc     = 0;
                    dot_acc    = 0;
                    pair_count = 0;
                    sat_flag   = 1'b0;
                end
            end

            // Compare each result item with the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.distance   = m_axis_tdata[25:0];
                got.zero_norm  = m_axis_tdata[26];
                got.overflowed = m_axis_tdata[27];
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: distance %0d", got.distance);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.distance !== exp_r.distance)
                    begin
                        $error("distance: expected %0d, got %0d", exp_r.distance,
                               got.distance);
                        fail_count++;
                    end
                    if (got.zero_norm !== exp_r.zero_norm)
                    begin
                        $error("zero_norm: expected %0d, got %0d", exp_r.zero_norm,
                               got.zero_norm);
                        fail_count++;
                    end
                    if (got.overflowed !== exp_r.overflowed)
                    begin
                        $error("overflowed: expected %0d, got %0d", exp_r.overflowed,
                               got.overflowed);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives element pairs and metric writes into the distance unit with bursty
// input and a stalling receiver; the checker beside the unit judges results.
// ----------------------------------------------------------------------------
module testbench;
    import vdm_pkg::*;

    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         PAIR_TARGET    = 1130;
    // Unused metric code, handled as L1
    localparam logic [1:0] MET_SPARE      = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          idle_cycles;
    int          pairs_sent;
    int          burst_left;
    int          stall_left;
    int          run_left;

    vector_distance_metrics_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    distance_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Stall the receiver: alternate ready runs and stall runs of random length
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            run_left      <= 0;
        end
        else if (run_left == 0)
        begin
            m_axis_tready <= !m_axis_tready;
            run_left      <= m_axis_tready ? $urandom_range(0, 30) : $urandom_range(0, 60);
        end
        else
            run_left <= run_left - 1;
    end

    // Count cycles with no accepted item on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Send one pair; hold valid between items of a burst, drop it in gaps
    task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input logic last);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6))
                @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pairs_sent++;
        @(negedge clk);
    endtask

    // Wait for every result, let the back stage settle, then write the metric
    task automatic write_metric(input logic [1:0] m);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom());
        endcase
    endfunction

    // Send one vector with random content in one of several shapes
    task automatic send_vector(input int len);
        int          shape;
        logic [15:0] x;
        logic [15:0] y;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < len; i++)
        begin
            x = pick_value();
            y = pick_value();
            case (shape)
                0: y = x;
                1: y = -x;
                2: x = 16'h0000;
                3: y = 16'h0000;
                default: ;
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    initial
    begin
        logic [1:0] phase_metric;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = MET_L1;
        pairs_sent    = 0;
        burst_left    = 0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes under each metric
        send_pair(16'h7FFF, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b0);
        send_pair(16'h0000, 16'h0000, 1'b1);
        write_metric(MET_L2);
        send_pair(16'h7FFF, 16'h8000, 1'b0);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b1);
        write_metric(MET_COS);
        // Same direction, opposite direction, and zero norms
        send_pair(16'h0100, 16'h0100, 1'b0);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h7FFF, 16'h8001, 1'b1);
        send_pair(16'h0000, 16'h0123, 1'b1);
        send_pair(16'h0456, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h0100, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'h0100, 1'b1);
        write_metric(MET_SPARE);
        send_pair(16'h8000, 16'h7FFF, 1'b0);
        send_pair(16'h1234, 16'hFEDC, 1'b1);

        // Overlong vector of extreme pairs: length and absolute-sum saturation
        write_metric(MET_L1);
        for (int i = 0; i < 1030; i++)
            send_pair(16'h7FFF, 16'h8000, i == 1029);

        // Random vectors, mostly short, under changing metrics
        while (pairs_sent < PAIR_TARGET)
        begin
            phase_metric = $urandom_range(0, 3);
            write_metric(phase_metric);
            repeat ($urandom_range(4, 16))
                send_vector($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 6));
        end
        write_metric(MET_COS);
        repeat (3)
            send_vector(3);
        write_metric(MET_L1);

        $display("Covered %0d pairs and %0d results over L1, L2, cosine and metric three,",
                 pairs_sent, result_count);
        $display("including zero norms, opposite vectors and an overlong saturating vector.");
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/vdm_pkg.sv
hdl/vdm_datapath.sv
hdl/vdm_ctrl.sv
hdl/vector_distance_metrics_unit.sv
tb/distance_checker.sv
tb/testbench.sv
